### rtl/shape_outline_rasterizer_macros.svh
// Assertion macros shared by the checker of the outline rasterizer.
// No dependencies; expects i_clk and i_rst_n in the scope of use.
`ifndef SHAPE_OUTLINE_RASTERIZER_MACROS_SVH
`define SHAPE_OUTLINE_RASTERIZER_MACROS_SVH

// implication checked outside reset
`define SOR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define SOR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked always, reset included
`define SOR_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/sor_pkg.sv
// Package of the outline rasterizer: widths, codes, control types, constants.
// No dependencies.
`default_nettype none
package sor_pkg;
    localparam int IMAGE_SIZE_DEF  = 256;
    localparam int ANGLE_STEPS_DEF = 629;
    localparam int FW   = 11;           // input field width
    localparam int PW   = 8;            // pixel width
    localparam int QW   = 16;           // Q2.14 trig width
    localparam int FRAC = 14;
    localparam int CRW  = 13;           // coordinate width after add
    localparam int RECT_CNT_W = FW - 1;
    localparam longint COS_STEP_Q30 = 64'sd1073688137;
    localparam longint SIN_STEP_Q30 = 64'sd10737239;
    localparam logic [PW-1:0] PIX_WHITE = 8'd255;
    localparam logic [PW-1:0] PIX_BLACK = 8'd0;

    typedef logic signed [CRW-1:0] t_coord;

    typedef enum logic [1:0] {
        KIND_RECT = 2'd0,
        KIND_ELL  = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        EDGE_TOP, EDGE_BOT, EDGE_LEFT, EDGE_RIGHT
    } t_edge;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RSTART, S_TOP, S_BOT, S_LEFT, S_RIGHT,
        S_ELL, S_DRAIN, S_READ, S_RDONE
    } t_state;

    typedef struct packed {
        logic  load;
        logic  clr_step;
        logic  cnt_clr;
        logic  rect_step;
        t_edge side;
        logic  ell_step;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic w_neg;
        logic h_neg;
        logic last_w;
        logic last_h;
        logic last_k;
        logic busy;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

### rtl/sor_ctrl.sv
// Controller of the outline rasterizer: sequences clear, edges, ellipse, read.
// Depends on sor_pkg.
`default_nettype none
module sor_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_kind,
    output logic           o_ready,
    input  sor_pkg::t_stat i_stat,
    output sor_pkg::t_cmd  o_cmd
);
    import sor_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    unique case (i_kind)
                        KIND_RECT: n_state = S_RSTART;
                        KIND_ELL:  n_state = S_ELL;
                        KIND_READ: n_state = S_READ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RSTART: begin
                if (!i_stat.w_neg)      n_state = S_TOP;
                else if (!i_stat.h_neg) n_state = S_LEFT;
                else                    n_state = S_IDLE;
            end
            S_TOP: begin
                o_cmd.rect_step = 1'b1;
                o_cmd.side      = EDGE_TOP;
                if (i_stat.last_w) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = S_BOT;
                end
            end
            S_BOT: begin
                o_cmd.rect_step = 1'b1;
                o_cmd.side      = EDGE_BOT;
                if (i_stat.last_w) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = i_stat.h_neg ? S_IDLE : S_LEFT;
                end
            end
            S_LEFT: begin
                o_cmd.rect_step = 1'b1;
                o_cmd.side      = EDGE_LEFT;
                if (i_stat.last_h) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = S_RIGHT;
                end
            end
            S_RIGHT: begin
                o_cmd.rect_step = 1'b1;
                o_cmd.side      = EDGE_RIGHT;
                if (i_stat.last_h) n_state = S_IDLE;
            end
            S_ELL: begin
                o_cmd.ell_step = 1'b1;
                if (i_stat.last_k) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_stat.busy) n_state = S_IDLE;
            end
            S_READ: begin
                n_state = S_RDONE;
            end
            S_RDONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/sor_dp.sv
// Datapath of the outline rasterizer: item registers, counters, trig ROM,
// ellipse pipeline, frame store and output register. Depends on sor_pkg.
`default_nettype none
module sor_dp #(
    parameter int IMAGE_SIZE  = sor_pkg::IMAGE_SIZE_DEF,
    parameter int ANGLE_STEPS = sor_pkg::ANGLE_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sor_pkg::t_cmd                     i_cmd,
    output sor_pkg::t_stat                    o_stat,
    input  logic signed [sor_pkg::FW-1:0]     i_row,
    input  logic signed [sor_pkg::FW-1:0]     i_col,
    input  logic signed [sor_pkg::FW-1:0]     i_span_rows,
    input  logic signed [sor_pkg::FW-1:0]     i_span_cols,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [sor_pkg::PW-1:0]            o_pixel
);
    import sor_pkg::*;

    localparam int DEPTH = IMAGE_SIZE * IMAGE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(IMAGE_SIZE);
    localparam int KW    = $clog2(ANGLE_STEPS);
    localparam int NW    = (KW > RECT_CNT_W) ? KW : RECT_CNT_W;
    localparam int PRW   = FW - 1 + QW;
    localparam int SW    = PRW + 1;
    localparam int RND   = (1 << FRAC) - 1;

    typedef logic signed [QW-1:0] t_rom [ANGLE_STEPS];

    function automatic longint rnd_shift(longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic t_rom gen_rom(bit want_sin);
        t_rom   t;
        longint c;
        longint s;
        longint nc;
        longint ns;
        c = longint'(1) << 30;
        s = 0;
        for (int k = 0; k < ANGLE_STEPS; k++) begin
            t[k] = want_sin ? QW'(rnd_shift(s, 16)) : QW'(rnd_shift(c, 16));
            nc = rnd_shift(c * COS_STEP_Q30, 30) - rnd_shift(s * SIN_STEP_Q30, 30);
            ns = rnd_shift(s * COS_STEP_Q30, 30) + rnd_shift(c * SIN_STEP_Q30, 30);
            c = nc;
            s = ns;
        end
        return t;
    endfunction

    localparam t_rom COS_ROM = gen_rom(1'b0);
    localparam t_rom SIN_ROM = gen_rom(1'b1);

    function automatic logic in_img(t_coord r, t_coord c);
        return (r >= 0) && (r < t_coord'(IMAGE_SIZE)) && (c >= 0) && (c < t_coord'(IMAGE_SIZE));
    endfunction

    function automatic logic [AW-1:0] pix_addr(t_coord r, t_coord c);
        return AW'(AW'(r[CW-1:0]) * AW'(IMAGE_SIZE)) + AW'(c[CW-1:0]);
    endfunction

    // item registers
    logic signed [FW-1:0] r_row, r_col, r_h, r_w;
    logic signed [FW-2:0] r_hh, r_hw;
    logic signed [FW-1:0] hadj, wadj;

    assign hadj = i_span_rows + $signed({{(FW-1){1'b0}}, i_span_rows[FW-1]});
    assign wadj = i_span_cols + $signed({{(FW-1){1'b0}}, i_span_cols[FW-1]});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row <= i_row;
            r_col <= i_col;
            r_h   <= i_span_rows;
            r_w   <= i_span_cols;
            r_hh  <= (FW-1)'(hadj >>> 1);
            r_hw  <= (FW-1)'(wadj >>> 1);
        end
    end

    // counters
    logic [NW-1:0] r_cnt;
    logic [AW-1:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd.cnt_clr)                         r_cnt <= '0;
            else if (i_cmd.rect_step || i_cmd.ell_step) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
        end
    end

    // rectangle edge coordinates
    t_coord t13, l13, h13, w13, j13, rr, rc;
    assign t13 = t_coord'(r_row);
    assign l13 = t_coord'(r_col);
    assign h13 = t_coord'(r_h);
    assign w13 = t_coord'(r_w);
    assign j13 = t_coord'(r_cnt[RECT_CNT_W-1:0]);

    always_comb begin
        unique case (i_cmd.side)
            EDGE_TOP:   begin rr = t13;       rc = l13 + j13; end
            EDGE_BOT:   begin rr = t13 + h13; rc = l13 + j13; end
            EDGE_LEFT:  begin rr = t13 + j13; rc = l13;       end
            EDGE_RIGHT: begin rr = t13 + j13; rc = l13 + w13; end
            default:    begin rr = t13;       rc = l13;       end
        endcase
    end

    // ellipse pipeline: ROM read, multiply, offset and write
    logic                  r_va, r_vb;
    logic signed [QW-1:0]  r_cos, r_sin;
    logic signed [PRW-1:0] r_px, r_py;
    logic signed [SW-1:0]  sx, sy;
    t_coord                ex, ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_cmd.ell_step;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos <= COS_ROM[r_cnt[KW-1:0]];
        r_sin <= SIN_ROM[r_cnt[KW-1:0]];
        r_px  <= r_hw * r_cos;
        r_py  <= r_hh * r_sin;
    end

    assign sx = SW'(r_px) + (SW'(r_col) <<< FRAC);
    assign sy = SW'(r_py) + (SW'(r_row) <<< FRAC);
    assign ex = sx[SW-1] ? CRW'((sx + SW'(RND)) >>> FRAC) : CRW'(sx >>> FRAC);
    assign ey = sy[SW-1] ? CRW'((sy + SW'(RND)) >>> FRAC) : CRW'(sy >>> FRAC);

    // frame store
    logic [PW-1:0] mem [DEPTH];
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [PW-1:0] wdata, r_rd;

    assign raddr = pix_addr(t13, l13);

    always_comb begin
        we    = 1'b0;
        waddr = pix_addr(ey, ex);
        wdata = PIX_BLACK;
        priority if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = PIX_WHITE;
        end else if (i_cmd.rect_step) begin
            we    = in_img(rr, rc);
            waddr = pix_addr(rr, rc);
        end else if (r_vb) begin
            we    = in_img(ey, ex);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd <= mem[raddr];
    end

    // output register
    logic          r_ovalid;
    logic [PW-1:0] r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_pixel <= in_img(t13, l13) ? r_rd : PIX_BLACK;
    end

    assign o_valid = r_ovalid;
    assign o_pixel = r_pixel;

    always_comb begin
        o_stat.clr_last = (r_clr == AW'(DEPTH - 1));
        o_stat.w_neg    = r_w[FW-1];
        o_stat.h_neg    = r_h[FW-1];
        o_stat.last_w   = (r_cnt == NW'(r_w));
        o_stat.last_h   = (r_cnt == NW'(r_h));
        o_stat.last_k   = (r_cnt == NW'(ANGLE_STEPS - 1));
        o_stat.busy     = r_va || r_vb;
        o_stat.out_free = !r_ovalid || i_ready;
    end
endmodule
`default_nettype wire

### rtl/shape_outline_rasterizer.sv
// Read: frame store read register, then output register. Rectangle: top and
// bottom, then left and right edges (empty edge pairs skipped). Ellipse: one
// point per angle step, then a drain. One pixel written per cycle through the
// single frame store write port. One item at a time; a waiting result does not
// block the next item. Reset: frame store swept to white, no input taken
// meanwhile. Depends on sor_pkg, sor_ctrl, sor_dp.
`default_nettype none
module shape_outline_rasterizer #(
    parameter int IMAGE_SIZE  = sor_pkg::IMAGE_SIZE_DEF,
    parameter int ANGLE_STEPS = sor_pkg::ANGLE_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_kind,
    input  logic signed [sor_pkg::FW-1:0] i_row,
    input  logic signed [sor_pkg::FW-1:0] i_col,
    input  logic signed [sor_pkg::FW-1:0] i_span_rows,
    input  logic signed [sor_pkg::FW-1:0] i_span_cols,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sor_pkg::PW-1:0]        o_pixel
);
    import sor_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sor_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sor_dp #(
        .IMAGE_SIZE  (IMAGE_SIZE),
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_span_rows (i_span_rows),
        .i_span_cols (i_span_cols),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_pixel     (o_pixel)
    );
endmodule
`default_nettype wire

### rtl/sor_chk.sv
// Port-level checker of the outline rasterizer, bound to the top level.
// Depends on sor_pkg and shape_outline_rasterizer_macros.svh.
`default_nettype none
`include "shape_outline_rasterizer_macros.svh"
module sor_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [1:0]                    i_kind,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [sor_pkg::PW-1:0]        o_pixel
);
    import sor_pkg::*;

    `SOR_ASSERT_RST(a_reset_quiet, !i_rst_n, !o_valid && !o_ready)
    `SOR_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_pixel))
    `SOR_ASSERT_NXT(a_busy_after_beat, i_valid && o_ready && (i_kind == KIND_RECT || i_kind == KIND_ELL || i_kind == KIND_READ), !o_ready)
    `SOR_ASSERT_IMP(a_no_instant_result, $rose(o_valid), !$past(i_valid && o_ready))
endmodule

bind shape_outline_rasterizer sor_chk u_sor_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_kind  (i_kind),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_pixel (o_pixel)
);
`default_nettype wire

### bench/sor_frame_checker.sv
`timescale 1ns / 1ps
// Checker of the outline rasterizer: shadow frame store, Q2.14 trig tables,
// expected pixel queue, compare on output beats. Depends on sor_pkg only.
module sor_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_kind,
    input  logic signed [sor_pkg::FW-1:0] i_row,
    input  logic signed [sor_pkg::FW-1:0] i_col,
    input  logic signed [sor_pkg::FW-1:0] i_span_rows,
    input  logic signed [sor_pkg::FW-1:0] i_span_cols,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [sor_pkg::PW-1:0]        i_pixel,
    output int                            o_fail_count,
    output int                            o_pending
);
    import sor_pkg::*;

    localparam int SZ    = IMAGE_SIZE_DEF;
    localparam int STEPS = ANGLE_STEPS_DEF;

    logic [PW-1:0] shadow_frame [SZ*SZ];
    int            cos_tab [STEPS];
    int            sin_tab [STEPS];
    logic [PW-1:0] pixel_queue [$];

    initial o_fail_count = 0;
    assign o_pending = pixel_queue.size();

    function automatic longint round_sh(input longint v, input int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    initial begin
        longint c, s, nc, ns;
        c = 64'sd1 <<< 30;
        s = 0;
        for (int k = 0; k < STEPS; k++) begin
            cos_tab[k] = int'(round_sh(c, 16));
            sin_tab[k] = int'(round_sh(s, 16));
            nc = round_sh(c * COS_STEP_Q30, 30) - round_sh(s * SIN_STEP_Q30, 30);
            ns = round_sh(s * COS_STEP_Q30, 30) + round_sh(c * SIN_STEP_Q30, 30);
            c = nc;
            s = ns;
        end
        for (int p = 0; p < SZ*SZ; p++) shadow_frame[p] = PIX_WHITE;
    end

    function automatic bit on_frame(input int r, input int c);
        return r >= 0 && r < SZ && c >= 0 && c < SZ;
    endfunction

    task automatic blacken(input int r, input int c);
        if (on_frame(r, c)) shadow_frame[r*SZ + c] = PIX_BLACK;
    endtask

    task automatic apply_beat(input logic [1:0] k, input int r, input int c,
                              input int h, input int w);
        int hh, hw, x, y;
        case (k)
            KIND_RECT: begin
                for (int i = c; i <= c + w; i++) begin
                    blacken(r, i);
                    blacken(r + h, i);
                end
                for (int i = r; i <= r + h; i++) begin
                    blacken(i, c);
                    blacken(i, c + w);
                end
            end
            KIND_ELL: begin
                hh = h / 2;
                hw = w / 2;
                for (int n = 0; n < STEPS; n++) begin
                    x = (hw * cos_tab[n] + c * 16384) / 16384;
                    y = (hh * sin_tab[n] + r * 16384) / 16384;
                    blacken(y, x);
                end
            end
            KIND_READ:
                pixel_queue.push_back(on_frame(r, c) ? shadow_frame[r*SZ + c] : PIX_BLACK);
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                apply_beat(i_kind, int'(i_row), int'(i_col),
                           int'(i_span_rows), int'(i_span_cols));
            if (i_out_valid && i_out_ready) begin
                if (pixel_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel %0d", i_pixel));
                end else begin
                    if (i_pixel !== pixel_queue[0])
                        report_mismatch($sformatf("pixel got %0d exp %0d",
                                                  i_pixel, pixel_queue[0]));
                    void'(pixel_queue.pop_front());
                end
            end
        end
    end
endmodule

### bench/tb_shape_outline_rasterizer.sv
`timescale 1ns / 1ps
// Top of the outline rasterizer bench: clock, reset, bursty stimulus,
// stalling receiver, verdict. Depends on sor_pkg, sor_frame_checker, the block.
module tb_shape_outline_rasterizer;
    import sor_pkg::*;

    localparam int LIMIT    = 10_000_000;
    localparam int N_RANDOM = 560;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_kind = KIND_READ;
    logic signed [FW-1:0] i_row = '0, i_col = '0, i_span_rows = '0, i_span_cols = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [PW-1:0]     o_pixel;

    int  fail_count, pending;
    int  cycles = 0;
    int  items_sent = 0;
    int  burst_left = 0;
    bit  long_hold = 0;
    int  last_r = 0, last_c = 0, last_h = 0, last_w = 0;
    logic [1:0] last_k = KIND_RECT;

    shape_outline_rasterizer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_row(i_row), .i_col(i_col),
        .i_span_rows(i_span_rows), .i_span_cols(i_span_cols),
        .o_valid(o_valid), .i_ready(i_ready), .o_pixel(o_pixel)
    );

    sor_frame_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_kind(i_kind),
        .i_row(i_row), .i_col(i_col), .i_span_rows(i_span_rows),
        .i_span_cols(i_span_cols),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_pixel(o_pixel),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[shape_outline_rasterizer] ERROR");
            $finish;
        end
    end

    int ready_mode = 0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) ready_mode <= $urandom_range(0, 2);
        case (ready_mode)
            0:       i_ready <= !long_hold;
            1:       i_ready <= !long_hold && ($urandom_range(0, 3) != 0);
            default: i_ready <= !long_hold && ($urandom_range(0, 3) == 0);
        endcase
    end

    initial begin
        wait (items_sent == 150);
        long_hold = 1;
        repeat (5000) @(posedge i_clk);
        long_hold = 0;
    end

    // called at a clock edge; returns at the edge that accepts the beat
    task automatic send_beat(input logic [1:0] k, input int r, input int c,
                             input int h, input int w);
        int gap;
        i_valid     <= 1'b1;
        i_kind      <= k;
        i_row       <= r[FW-1:0];
        i_col       <= c[FW-1:0];
        i_span_rows <= h[FW-1:0];
        i_span_cols <= w[FW-1:0];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        if (k != KIND_READ && k != 2'd3) begin
            last_k = k; last_r = r; last_c = c; last_h = h; last_w = w;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic random_beat();
        int sel, r, c, t;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            send_beat($urandom_range(0, 3), $urandom_range(0, 2047) - 1024,
                      $urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                      $urandom_range(0, 2047) - 1024);
        end else if (sel < 35) begin
            send_beat(KIND_RECT, $urandom_range(0, 271) - 8, $urandom_range(0, 271) - 8,
                      $urandom_range(0, 43) - 3, $urandom_range(0, 43) - 3);
        end else if (sel < 55) begin
            send_beat(KIND_ELL, $urandom_range(0, 275) - 10, $urandom_range(0, 275) - 10,
                      $urandom_range(0, 360) - 60, $urandom_range(0, 360) - 60);
        end else if (sel < 85) begin
            t = $urandom_range(0, 2) - 1;
            if (last_k == KIND_RECT) begin
                r = ($urandom_range(0, 1) ? last_r : last_r + last_h) + t;
                c = last_c + ((last_w > 0) ? $urandom_range(0, last_w) : 0);
            end else begin
                r = last_r + t;
                c = last_c + last_w / 2;
            end
            send_beat(KIND_READ, r, c, $urandom_range(0, 2047) - 1024,
                      $urandom_range(0, 2047) - 1024);
        end else begin
            send_beat(KIND_READ, $urandom_range(0, 259) - 2, $urandom_range(0, 259) - 2,
                      0, 0);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, outside reads, extreme fields, degenerate edges, ellipses, the unused kind
        send_beat(KIND_READ, 0, 0, 0, 0);
        send_beat(KIND_READ, 255, 255, 1023, -1024);
        send_beat(KIND_READ, -1024, 1023, 0, 0);
        send_beat(KIND_READ, 256, 0, 0, 0);
        send_beat(KIND_RECT, 10, 20, 30, 40);
        send_beat(KIND_READ, 10, 45, 0, 0);
        send_beat(KIND_READ, 40, 20, 0, 0);
        send_beat(KIND_READ, 25, 60, 0, 0);
        send_beat(KIND_READ, 25, 30, 0, 0);
        send_beat(KIND_RECT, 100, 100, -5, 8);
        send_beat(KIND_RECT, 120, 120, 6, -1);
        send_beat(KIND_RECT, -1024, -1024, 1023, 1023);
        send_beat(KIND_RECT, 1023, 1023, -1024, -1024);
        send_beat(KIND_RECT, 250, 250, 0, 0);
        send_beat(KIND_READ, 250, 250, 0, 0);
        send_beat(KIND_ELL, 128, 128, 200, 100);
        send_beat(KIND_READ, 128, 178, 0, 0);
        send_beat(KIND_ELL, 0, 0, 1023, -1024);
        send_beat(KIND_ELL, -1024, 1023, -1, 1);
        send_beat(KIND_ELL, 60, 60, 0, 0);
        send_beat(KIND_READ, 60, 60, 0, 0);
        send_beat(2'd3, 5, 5, 5, 5);
        send_beat(KIND_READ, 1023, -1024, 0, 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            random_beat();
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (9000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[shape_outline_rasterizer] OK");
        else
            $display("[shape_outline_rasterizer] ERROR");
        $finish;
    end
endmodule
